/* rtl/bps_pkg.sv */
// ---------------------------------------------------------------------------
// bps_pkg: shared types and constants of the block pacing schedule
// Register map, plan status codes and the structs between plan and datapath.
// ---------------------------------------------------------------------------
package bps_pkg;

   // Register indices from paddr[4:3] (byte address 8x index, data bus 64 bits)
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
   localparam logic [1:0] REG_TARGET_RATE = 2'd1;
   localparam logic [1:0] REG_RUN_SECONDS = 2'd2;

   localparam logic [31:0] BLOCK_SIZE_RST = 32'd4096;
   localparam logic [47:0] TARGET_RATE_RST = 48'd100000000000;
   localparam logic [31:0] RUN_SECONDS_RST = 32'd1;

   // Plan status codes
   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_ZERO_SIZE = 3'd1;
   localparam logic [2:0] STATUS_ZERO_RATE = 3'd2;
   localparam logic [2:0] STATUS_ZERO_RUN = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

   // Blocks per second never exceeds 2^45, so it fits in 46 bits
   localparam int unsigned BPS_W = 46;

   typedef struct packed {
      logic [31:0] block_size;
      logic [47:0] target_rate;
      logic [31:0] run_seconds;
   } cfg_type;

   typedef struct packed {
      logic        busy;
      logic [2:0]  status;
      logic [63:0] bps;
      logic [63:0] count;
      logic [63:0] bytes_ps;
      logic [63:0] total;
   } plan_type;

endpackage

/* rtl/bps_if.sv */
// ---------------------------------------------------------------------------
// bps_req_if / bps_rsp_if: item channels of the block pacing schedule
// Valid/ready channels; an item moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface bps_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_number;

   modport source (output valid, output block_number, input ready);
   modport sink (input valid, input block_number, output ready);
endinterface

interface bps_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] offset_ns;
   logic [2:0]  plan_status;
   logic [63:0] blocks_each_second;
   logic [63:0] planned_blocks;
   logic [63:0] paced_bytes_per_second;
   logic [63:0] planned_total_bytes;

   modport source (output valid, output offset_ns, output plan_status,
                   output blocks_each_second, output planned_blocks,
                   output paced_bytes_per_second, output planned_total_bytes,
                   input ready);
   modport sink (input valid, input offset_ns, input plan_status,
                 input blocks_each_second, input planned_blocks,
                 input paced_bytes_per_second, input planned_total_bytes,
                 output ready);
endinterface

/* rtl/block_pacing_schedule.sv */
// ---------------------------------------------------------------------------
// block_pacing_schedule: send offset of each block under a pacing plan
// Answers one block index per cycle with its send offset in nanoseconds, unless held by a stall or a plan update.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries a block index, rsp_chan returns its offset together with
//   the plan (status, blocks per second, block count, byte rates). The csr_
//   port writes block size, bit rate and run length at addresses 0, 8, 16.
//   After reset and after every register write the plan is recomputed by a
//   bit-serial divider and multiplier, during which req_chan.ready stays
//   low. Offsets then run through a row of 64 division cells (index / blocks
//   per second), two multiply stages and 30 more cells (fraction of a
//   second) to an output register that drives rsp_chan.valid, at one item
//   per cycle while the receiver takes items and no plan is computed.
//   When the receiver stalls, the whole row holds; items already in flight
//   keep their places and no item is lost.
//   Reset clears all valid flags, loads the register defaults and starts a
//   plan computation.
// ---------------------------------------------------------------------------
module block_pacing_schedule
   import bps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bps_req_if.sink               req_chan,
   bps_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int A_CELLS = 64;
   localparam int B_CELLS = 30;

   cfg_type  cfg_ff;
   plan_type plan;
   logic     csr_write;
   logic     enable;
   logic     accept;

   logic                  a_valid [A_CELLS+1];
   logic [BPS_W-1:0]      a_rem   [A_CELLS+1];
   logic [63:0]           a_word  [A_CELLS+1];
   logic                  b_valid [B_CELLS+1];
   logic [BPS_W-1:0]      b_rem   [B_CELLS+1];
   logic [29:0]           b_word  [B_CELLS+1];
   logic [64:0]           side_ff [B_CELLS];

   logic                  m1_valid_ff;
   logic [61:0]           sec_lo_ff;
   logic [61:0]           sec_hi_ff;
   logic [52:0]           rem_lo_ff;
   logic [52:0]           rem_hi_ff;
   logic                  m2_valid_ff;
   logic [93:0]           whole_ff;
   logic [75:0]           num_ff;
   logic                  rsp_valid_ff;
   logic [63:0]           offset_ff;
   logic [64:0]           sum;
   logic [BPS_W-1:0]      divisor;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size  <= BLOCK_SIZE_RST;
         cfg_ff.target_rate <= TARGET_RATE_RST;
         cfg_ff.run_seconds <= RUN_SECONDS_RST;
      end else if (csr_write) begin
         unique case (csr_paddr[4:3])
            REG_BLOCK_SIZE:  cfg_ff.block_size  <= csr_pwdata[31:0];
            REG_TARGET_RATE: cfg_ff.target_rate <= csr_pwdata[47:0];
            REG_RUN_SECONDS: cfg_ff.run_seconds <= csr_pwdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[4:3])
         REG_BLOCK_SIZE:  csr_prdata = {32'd0, cfg_ff.block_size};
         REG_TARGET_RATE: csr_prdata = {16'd0, cfg_ff.target_rate};
         REG_RUN_SECONDS: csr_prdata = {32'd0, cfg_ff.run_seconds};
         default:         csr_prdata = 64'd0;
      endcase
   end

   bps_plan u_plan (
      .clock (clock),
      .reset (reset),
      .start (csr_write),
      .cfg   (cfg_ff),
      .plan  (plan)
   );

   // whole row moves unless the output item is held
   assign enable         = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = enable & ~plan.busy & ~csr_write;
   assign accept         = req_chan.valid & req_chan.ready;
   assign divisor        = plan.bps[BPS_W-1:0];

   // index / blocks per second
   assign a_valid[0] = accept;
   assign a_rem[0]   = '0;
   assign a_word[0]  = req_chan.block_number;

   for (genvar i = 0; i < A_CELLS; i++) begin : g_sec
      bps_cell #(.RW(BPS_W), .WW(64)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .divisor   (divisor),
         .in_valid  (a_valid[i]),
         .in_rem    (a_rem[i]),
         .in_word   (a_word[i]),
         .out_valid (a_valid[i+1]),
         .out_rem   (a_rem[i+1]),
         .out_word  (a_word[i+1])
      );
   end

   // partial products of seconds and remainder by 1e9
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (enable) begin
         m1_valid_ff <= a_valid[A_CELLS];
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sec_lo_ff <= a_word[A_CELLS][31:0] * NS_PER_SEC;
         sec_hi_ff <= a_word[A_CELLS][63:32] * NS_PER_SEC;
         rem_lo_ff <= a_rem[A_CELLS][22:0] * NS_PER_SEC;
         rem_hi_ff <= a_rem[A_CELLS][45:23] * NS_PER_SEC;
         whole_ff  <= {32'd0, sec_lo_ff} + {sec_hi_ff, 32'd0};
         num_ff    <= {23'd0, rem_lo_ff} + {rem_hi_ff, 23'd0};
      end
   end

   // fraction: the top bits already sit below the divisor
   assign b_valid[0] = m2_valid_ff;
   assign b_rem[0]   = num_ff[75:30];
   assign b_word[0]  = num_ff[29:0];

   for (genvar j = 0; j < B_CELLS; j++) begin : g_frac
      bps_cell #(.RW(BPS_W), .WW(30)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .divisor   (divisor),
         .in_valid  (b_valid[j]),
         .in_rem    (b_rem[j]),
         .in_word   (b_word[j]),
         .out_valid (b_valid[j+1]),
         .out_rem   (b_rem[j+1]),
         .out_word  (b_word[j+1])
      );
   end

   // carry the whole-second part beside the fraction cells
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= {|whole_ff[93:64], whole_ff[63:0]};
         for (int k = 1; k < B_CELLS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // final sum, saturate on overflow or error
   assign sum = {1'b0, side_ff[B_CELLS-1][63:0]} + {35'd0, b_word[B_CELLS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= b_valid[B_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (plan.status != STATUS_OK || side_ff[B_CELLS-1][64] || sum[64]) begin
            offset_ff <= '1;
         end else begin
            offset_ff <= sum[63:0];
         end
      end
   end

   assign rsp_chan.valid                  = rsp_valid_ff;
   assign rsp_chan.offset_ns              = offset_ff;
   assign rsp_chan.plan_status            = plan.status;
   assign rsp_chan.blocks_each_second     = plan.bps;
   assign rsp_chan.planned_blocks         = plan.count;
   assign rsp_chan.paced_bytes_per_second = plan.bytes_ps;
   assign rsp_chan.planned_total_bytes    = plan.total;

   // no item enters while the plan is recomputed
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      plan.busy |-> !req_chan.ready)
      else $error("item taken during plan update");

   // a register write restarts the plan
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> plan.busy)
      else $error("plan not restarted after write");

   // an error plan always saturates the offset
   a_error_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && plan.status != STATUS_OK) |-> (rsp_chan.offset_ns == '1))
      else $error("error without saturated offset");

   // an error plan carries no rate
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!plan.busy && plan.status != STATUS_OK) |-> (plan.bps == 64'd0))
      else $error("error plan with nonzero rate");

endmodule

/* rtl/bps_cell.sv */
// ---------------------------------------------------------------------------
// bps_cell: one restoring-division step of the pacing datapath
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the word.
// ---------------------------------------------------------------------------
module bps_cell #(
   parameter int RW = 46,
   parameter int WW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic [RW-1:0] divisor,
   input  logic          in_valid,
   input  logic [RW-1:0] in_rem,
   input  logic [WW-1:0] in_word,
   output logic          out_valid,
   output logic [RW-1:0] out_rem,
   output logic [WW-1:0] out_word
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff;
   logic [WW-1:0] word_ff;
   logic [RW:0]   shifted;
   logic [RW:0]   diff;
   logic          fits;
   logic [RW-1:0] rem_in;
   logic [WW-1:0] word_in;

   // trial subtract of the divisor
   assign shifted = {in_rem, in_word[WW-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};
   assign rem_in  = fits ? diff[RW-1:0] : shifted[RW-1:0];
   assign word_in = {in_word[WW-2:0], fits};

   // advance when the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_word  = word_ff;

endmodule

/* rtl/bps_plan.sv */
// ---------------------------------------------------------------------------
// bps_plan: sequential derivation of the pacing plan
// Checks the registers, divides the byte rate by the block size one bit a
// cycle and forms the three 64x32 plan products with a bit-serial multiplier.
// ---------------------------------------------------------------------------
module bps_plan
   import bps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  cfg_type  cfg,
   output plan_type plan
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_DIV, S_LOAD, S_MUL, S_DONE
   } state_type;

   state_type    state_ff;
   logic [45:0]  num_ff;
   logic [31:0]  drem_ff;
   logic [5:0]   cnt_ff;
   logic [1:0]   op_ff;
   logic [95:0]  acc_ff;
   logic [95:0]  mcand_ff;
   logic [31:0]  mplier_ff;
   logic         ovf_ff;
   logic [2:0]   status_ff;
   logic [63:0]  bps_ff;
   logic [63:0]  count_ff;
   logic [63:0]  bytes_ps_ff;
   logic [63:0]  total_ff;

   logic [32:0]  dshift;
   logic [32:0]  ddiff;
   logic         dfits;
   logic [95:0]  acc_sum;
   logic [45:0]  bytes_rate;

   // round the bit rate up to bytes
   assign bytes_rate = {1'b0, cfg.target_rate[47:3]} + {45'd0, |cfg.target_rate[2:0]};

   // one division step
   assign dshift = {drem_ff, num_ff[45]};
   assign ddiff  = dshift - {1'b0, cfg.block_size};
   assign dfits  = dshift >= {1'b0, cfg.block_size};

   // one multiplication step
   assign acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : 96'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CHECK;
         status_ff <= STATUS_OK;
      end else if (start) begin
         state_ff <= S_CHECK;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               state_ff <= S_IDLE;
            end
            S_CHECK: begin
               ovf_ff  <= 1'b0;
               op_ff   <= 2'd0;
               cnt_ff  <= 6'd0;
               num_ff  <= bytes_rate;
               drem_ff <= 32'd0;
               if (cfg.block_size == 32'd0) begin
                  status_ff <= STATUS_ZERO_SIZE;
                  state_ff  <= S_DONE;
               end else if (cfg.target_rate == 48'd0) begin
                  status_ff <= STATUS_ZERO_RATE;
                  state_ff  <= S_DONE;
               end else if (cfg.run_seconds == 32'd0) begin
                  status_ff <= STATUS_ZERO_RUN;
                  state_ff  <= S_DONE;
               end else begin
                  status_ff <= STATUS_OK;
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               drem_ff <= dfits ? ddiff[31:0] : dshift[31:0];
               num_ff  <= {num_ff[44:0], dfits};
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd45) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               // round the quotient up once the division is through
               if (op_ff == 2'd0) begin
                  bps_ff   <= {18'd0, num_ff} + {63'd0, drem_ff != 32'd0};
                  mcand_ff <= {50'd0, num_ff} + {95'd0, drem_ff != 32'd0};
                  mplier_ff <= cfg.block_size;
               end else if (op_ff == 2'd1) begin
                  mcand_ff  <= {32'd0, bps_ff};
                  mplier_ff <= cfg.run_seconds;
               end else begin
                  mcand_ff  <= {32'd0, count_ff};
                  mplier_ff <= cfg.block_size;
               end
               acc_ff   <= 96'd0;
               cnt_ff   <= 6'd0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               acc_ff    <= acc_sum;
               mcand_ff  <= {mcand_ff[94:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[31:1]};
               cnt_ff    <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  ovf_ff <= ovf_ff | (|acc_sum[95:64]);
                  if (op_ff == 2'd0) begin
                     bytes_ps_ff <= acc_sum[63:0];
                  end else if (op_ff == 2'd1) begin
                     count_ff <= acc_sum[63:0];
                  end else begin
                     total_ff <= acc_sum[63:0];
                  end
                  op_ff    <= op_ff + 2'd1;
                  state_ff <= (op_ff == 2'd2) ? S_DONE : S_LOAD;
               end
            end
            S_DONE: begin
               // drop the plan on any error
               if (status_ff != STATUS_OK || ovf_ff) begin
                  if (status_ff == STATUS_OK) begin
                     status_ff <= STATUS_OVERFLOW;
                  end
                  bps_ff      <= 64'd0;
                  count_ff    <= 64'd0;
                  bytes_ps_ff <= 64'd0;
                  total_ff    <= 64'd0;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign plan.busy     = state_ff != S_IDLE;
   assign plan.status   = status_ff;
   assign plan.bps      = bps_ff;
   assign plan.count    = count_ff;
   assign plan.bytes_ps = bytes_ps_ff;
   assign plan.total    = total_ff;

endmodule

/* tb/sv/bps_tb_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bps_tb_if: no extra channel types are needed in the testbench
// The item channels come from the RTL interface file (bps_req_if, bps_rsp_if).
// This file holds the testbench-side result record shared by the top module.
// ---------------------------------------------------------------------------
package bps_tb_pkg;

   // One expected result item of the pacing schedule
   typedef struct packed {
      logic [63:0] offset_ns;
      logic [2:0]  plan_status;
      logic [63:0] blocks_each_second;
      logic [63:0] planned_blocks;
      logic [63:0] paced_bytes_per_second;
      logic [63:0] planned_total_bytes;
   } sched_result_type;

endpackage

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench of the block pacing schedule
// Writes pacing settings over the csr port between phases, sends block
// indices with random gaps, predicts each offset and plan at 128-bit width
// and compares every returned item field by field under random back-pressure.
// ---------------------------------------------------------------------------
module tb;
   import bps_pkg::*;
   import bps_tb_pkg::*;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [127:0] NS_WIDE = 128'd1000000000;
   localparam int unsigned DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   bps_req_if req_chan ();
   bps_rsp_if rsp_chan ();

   block_pacing_schedule dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Pacing settings as the block should hold them
   logic [31:0] size_setting = BLOCK_SIZE_RST;
   logic [47:0] rate_setting = TARGET_RATE_RST;
   logic [31:0] run_setting = RUN_SECONDS_RST;

   logic [63:0] pending_blocks[$];
   sched_result_type expected_results[$];
   int unsigned fail_count = 0;
   int unsigned checked_count = 0;
   int unsigned status_hits[5] = '{default: 0};
   int unsigned saturated_count = 0;
   bit calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;

   always #5 clock = ~clock;

   // Blocks per second under the current settings, zero when a setting is zero
   function automatic logic [127:0] block_rate();
      logic [127:0] bytes_ps;
      if (size_setting == 0 || rate_setting == 0 || run_setting == 0) return '0;
      bytes_ps = (128'(rate_setting) + 7) / 8;
      return (bytes_ps + 128'(size_setting) - 1) / 128'(size_setting);
   endfunction

   // Expected result item for one block index
   function automatic sched_result_type schedule_offset(logic [63:0] index);
      sched_result_type res;
      logic [127:0] bps, bytes_ps, count, total, whole, frac;
      res = '0;
      res.offset_ns = ALL_ONES;
      bps = block_rate();
      bytes_ps = bps * 128'(size_setting);
      count = bps * 128'(run_setting);
      total = count * 128'(size_setting);
      if (size_setting == 0) res.plan_status = STATUS_ZERO_SIZE;
      else if (rate_setting == 0) res.plan_status = STATUS_ZERO_RATE;
      else if (run_setting == 0) res.plan_status = STATUS_ZERO_RUN;
      else if (bytes_ps[127:64] != 0 || count[127:64] != 0 || total[127:64] != 0)
         res.plan_status = STATUS_OVERFLOW;
      else begin
         res.plan_status = STATUS_OK;
         res.blocks_each_second = bps[63:0];
         res.planned_blocks = count[63:0];
         res.paced_bytes_per_second = bytes_ps[63:0];
         res.planned_total_bytes = total[63:0];
         whole = (128'(index) / bps) * NS_WIDE;
         frac = ((128'(index) % bps) * NS_WIDE) / bps;
         if (whole + frac <= 128'(ALL_ONES)) res.offset_ns = 64'(whole + frac);
      end
      return res;
   endfunction

   // Driver: present queued block indices, with random gap bursts
   always @(posedge clock) begin
      logic [63:0] next_block;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.block_number <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_results.push_back(schedule_offset(req_chan.block_number));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_blocks.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(0, 7);
               req_chan.valid <= 1'b0;
            end else begin
               next_block = pending_blocks.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.block_number <= next_block;
            end
         end
      end
   end

   // Monitor: random stall bursts, compare each item with the oldest prediction
   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("result item with no prediction waiting");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (want.plan_status <= STATUS_OVERFLOW) status_hits[want.plan_status]++;
               if (want.plan_status == STATUS_OK && want.offset_ns == ALL_ONES)
                  saturated_count++;
               if (rsp_chan.offset_ns !== want.offset_ns) begin
                  $error("offset_ns: expected %0h actual %0h", want.offset_ns,
                         rsp_chan.offset_ns);
                  fail_count++;
               end
               if (rsp_chan.plan_status !== want.plan_status) begin
                  $error("plan_status: expected %0d actual %0d", want.plan_status,
                         rsp_chan.plan_status);
                  fail_count++;
               end
               if (rsp_chan.blocks_each_second !== want.blocks_each_second) begin
                  $error("blocks_each_second: expected %0d actual %0d",
                         want.blocks_each_second, rsp_chan.blocks_each_second);
                  fail_count++;
               end
               if (rsp_chan.planned_blocks !== want.planned_blocks) begin
                  $error("planned_blocks: expected %0d actual %0d", want.planned_blocks,
                         rsp_chan.planned_blocks);
                  fail_count++;
               end
               if (rsp_chan.paced_bytes_per_second !== want.paced_bytes_per_second) begin
                  $error("paced_bytes_per_second: expected %0d actual %0d",
                         want.paced_bytes_per_second, rsp_chan.paced_bytes_per_second);
                  fail_count++;
               end
               if (rsp_chan.planned_total_bytes !== want.planned_total_bytes) begin
                  $error("planned_total_bytes: expected %0d actual %0d",
                         want.planned_total_bytes, rsp_chan.planned_total_bytes);
                  fail_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Wait until every item has gone through and the pipeline has emptied
   task automatic wait_idle();
      while (pending_blocks.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle
   task automatic csr_write(logic [1:0] reg_index, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({reg_index, 3'b000});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (reg_index)
         REG_BLOCK_SIZE: size_setting = value[31:0];
         REG_TARGET_RATE: rate_setting = value[47:0];
         REG_RUN_SECONDS: run_setting = value[31:0];
         default: ;
      endcase
   endtask

   task automatic apply_plan(logic [31:0] size_v, logic [47:0] rate_v, logic [31:0] run_v);
      wait_idle();
      csr_write(REG_BLOCK_SIZE, 64'(size_v));
      csr_write(REG_TARGET_RATE, 64'(rate_v));
      csr_write(REG_RUN_SECONDS, 64'(run_v));
   endtask

   // Index near a second boundary, small, huge or fully random
   function automatic logic [63:0] pick_block();
      logic [127:0] bps;
      logic [63:0] raw;
      bps = block_rate();
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return 64'($urandom_range(0, 1000));
         1: return (bps == 0) ? raw : 64'(bps * $urandom_range(0, 4)) - 64'($urandom_range(0, 1));
         2: return raw >> $urandom_range(0, 63);
         3: return ALL_ONES - 64'($urandom_range(0, 3));
         default: return raw;
      endcase
   endfunction

   task automatic send_blocks(int unsigned n);
      repeat (n) pending_blocks.push_back(pick_block());
   endtask

   initial begin
      logic [31:0] size_v, run_v;
      logic [47:0] rate_v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset plan: boundary indices
      pending_blocks.push_back(64'd0);
      pending_blocks.push_back(64'd1);
      pending_blocks.push_back(64'(block_rate()) - 64'd1);
      pending_blocks.push_back(64'(block_rate()));
      pending_blocks.push_back(64'h8000_0000_0000_0000);
      pending_blocks.push_back(ALL_ONES);
      pending_blocks.push_back(64'h5555_5555_5555_5555);
      pending_blocks.push_back(64'hAAAA_AAAA_AAAA_AAAA);

      // Each zero setting, ordering of errors, product overflow
      apply_plan(32'd0, 48'd0, 32'd0);
      pending_blocks.push_back(64'd5);
      apply_plan(32'd8, 48'd0, 32'd0);
      pending_blocks.push_back(64'd5);
      apply_plan(32'd8, 48'd64, 32'd0);
      pending_blocks.push_back(64'd5);
      apply_plan(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      pending_blocks.push_back(64'd5);
      // One block per second: whole-second product overflows for large indices
      apply_plan(32'd1, 48'd1, 32'd1);
      pending_blocks.push_back(64'd18446744073);
      pending_blocks.push_back(64'd18446744074);
      pending_blocks.push_back(ALL_ONES);
      // Rate not a multiple of eight bits, extreme block rate
      apply_plan(32'd3, 48'd9, 32'd1);
      pending_blocks.push_back(64'd7);
      apply_plan(32'd1, 48'hFFFF_FFFF_FFFF, 32'd1);
      pending_blocks.push_back(ALL_ONES);
      pending_blocks.push_back(64'd123456789);
      // Write to an unknown register is dropped
      wait_idle();
      csr_write(2'd3, ALL_ONES);
      pending_blocks.push_back(64'd77);

      // Random settings, mostly valid plans
      for (int phase = 0; phase < 22; phase++) begin
         if (phase >= 19) calm = 1'b1;
         case ($urandom_range(0, 3))
            0: size_v = $urandom_range(1, 64);
            1: size_v = $urandom;
            2: size_v = 32'hFFFF_FFFF;
            default: size_v = 32'd1 << $urandom_range(0, 31);
         endcase
         rate_v = 48'({$urandom, $urandom} >> $urandom_range(16, 47));
         run_v = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 100);
         if ($urandom_range(0, 9) == 0) size_v = 0;
         if ($urandom_range(0, 9) == 0) rate_v = 0;
         if ($urandom_range(0, 9) == 0) run_v = 0;
         apply_plan(size_v, rate_v, run_v);
         send_blocks(50);
      end
      wait_idle();

      $display("checked %0d items: ok %0d, zero size %0d, zero rate %0d, zero run %0d",
               checked_count, status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      $display("plan overflow %0d, saturated offsets %0d", status_hits[4], saturated_count);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("PASS block_pacing_schedule");
      end else begin
         $display("FAIL block_pacing_schedule");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5ms;
      $display("FAIL block_pacing_schedule");
      $finish;
   end

endmodule
